/* sv/rsbn_pkg.sv */
// Shared types, field widths and the sequencer program of the record sorter.
package rsbn_pkg;

  localparam int KEY_W = 64;
  localparam int TAG_W = 16;
  localparam int REC_W = KEY_W + TAG_W;
  localparam int UPC_W = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_LAST,
    COND_SHORT,
    COND_BUSY,
    COND_MORE_J,
    COND_MORE_I,
    COND_MORE_K
  } cond_t;

  typedef enum logic {
    RD_I,
    RD_J
  } rd_sel_t;

  // Step addresses of the program.
  localparam upc_t STEP_IDLE  = 4'd0;
  localparam upc_t STEP_SETUP = 4'd1;
  localparam upc_t STEP_LDI   = 4'd2;
  localparam upc_t STEP_GETI  = 4'd3;
  localparam upc_t STEP_RDJ   = 4'd4;
  localparam upc_t STEP_CMP   = 4'd5;
  localparam upc_t STEP_PUTI  = 4'd6;
  localparam upc_t STEP_KINIT = 4'd7;
  localparam upc_t STEP_RDK   = 4'd8;
  localparam upc_t STEP_EMIT  = 4'd9;
  localparam upc_t STEP_DONE  = 4'd10;

  typedef struct packed {
    cond_t   cond;
    upc_t    target;
    logic    accept;
    logic    clr_i;
    logic    set_j;
    logic    inc_i;
    logic    inc_j;
    logic    latch_cur;
    rd_sel_t rd_sel;
    logic    try_swap;
    logic    wr_i;
    logic    emit;
    logic    clr_set;
  } ctrl_t;

  typedef struct packed {
    logic not_last;
    logic short_set;
    logic out_busy;
    logic more_j;
    logic more_i;
    logic more_k;
  } stat_t;

  function automatic ctrl_t ucode_rom(upc_t addr);
    ctrl_t w;
    w = '0;
    w.cond = COND_NEVER;
    w.target = STEP_IDLE;
    w.rd_sel = RD_I;
    case (addr)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond = COND_NOT_LAST;
        w.target = STEP_IDLE;
      end
      STEP_SETUP: begin
        w.clr_i = 1'b1;
        w.cond = COND_SHORT;
        w.target = STEP_KINIT;
      end
      STEP_LDI: begin
        w.rd_sel = RD_I;
        w.set_j = 1'b1;
      end
      STEP_GETI: begin
        w.latch_cur = 1'b1;
      end
      STEP_RDJ: begin
        w.rd_sel = RD_J;
      end
      STEP_CMP: begin
        w.try_swap = 1'b1;
        w.inc_j = 1'b1;
        w.cond = COND_MORE_J;
        w.target = STEP_RDJ;
      end
      STEP_PUTI: begin
        w.wr_i = 1'b1;
        w.inc_i = 1'b1;
        w.cond = COND_MORE_I;
        w.target = STEP_LDI;
      end
      STEP_KINIT: begin
        w.clr_i = 1'b1;
      end
      STEP_RDK: begin
        w.rd_sel = RD_I;
        w.cond = COND_BUSY;
        w.target = STEP_RDK;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.inc_i = 1'b1;
        w.cond = COND_MORE_K;
        w.target = STEP_RDK;
      end
      STEP_DONE: begin
        w.clr_set = 1'b1;
        w.cond = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/record_sort_by_name_key.sv */
// Top level of the record sorter: record store, sort datapath and result register.
//
// Records (name key plus tag) load into a DEPTH-entry store at one
// transaction per cycle. Keys are stored in canonical form: only the low
// 8*NAME_BYTES bits count, and every byte after the first zero byte is
// cleared. A record that arrives while the store holds DEPTH records is
// dropped and sets the overflow flag reported on every result of that set.
// The transaction with in_last_item high closes the set: input stalls while
// a microcoded sequencer runs an exchange sort over the n held records and
// then streams them out in ascending key order, out_final_result marking the
// last one. The sort holds record i in a register and walks j over the later
// entries through the single read port of the store; each compare reads slot
// j and then compares it with the held record. Output reads each record and
// loads it into the result register, waiting while the receiver stalls.
// The next set may start loading while the final result still waits to be
// taken.
module record_sort_by_name_key
  import rsbn_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int NAME_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] in_name_key,
  input  logic [TAG_W-1:0] in_record_tag,
  input  logic             in_last_item,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_sorted_key,
  output logic [TAG_W-1:0] out_sorted_tag,
  output logic             out_final_result,
  output logic             out_overflow_seen
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ctrl_t ctrl;
  stat_t stat;
  upc_t  upc;

  // Store and sort state
  logic [CW-1:0]    count_r;
  logic             drop_r;
  logic [AW-1:0]    i_r;
  logic [AW-1:0]    j_r;
  logic [KEY_W-1:0] cur_key_r;
  logic [TAG_W-1:0] cur_tag_r;

  // Result register
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic [TAG_W-1:0] out_tag_r;
  logic             out_final_r;
  logic             out_ovf_r;

  logic             in_acc;
  logic             full;
  logic [CW-1:0]    count_m1;
  logic [AW-1:0]    last_idx;
  logic [AW-1:0]    i_inc;
  logic [KEY_W-1:0] canon_key;
  logic             name_alive;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [REC_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [REC_W-1:0] rd_data;
  logic [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0] rd_tag;
  logic             swap_hit;

  rsbn_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl),
    .upc  (upc)
  );

  rsbn_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_stall = !ctrl.accept;
  assign in_acc   = in_valid && ctrl.accept;
  assign full     = (count_r == CW'(DEPTH));
  assign count_m1 = count_r - CW'(1);
  assign last_idx = count_m1[AW-1:0];
  assign i_inc    = i_r + AW'(1);

  assign rd_key = rd_data[REC_W-1:TAG_W];
  assign rd_tag = rd_data[TAG_W-1:0];

  // Canonical key: keep name bytes from the top down until the first NUL.
  always_comb begin
    canon_key  = '0;
    name_alive = 1'b1;
    for (int n = 0; n < NAME_BYTES; n++) begin
      if (in_name_key[8*(NAME_BYTES-1-n) +: 8] == 8'd0) begin
        name_alive = 1'b0;
      end
      if (name_alive) begin
        canon_key[8*(NAME_BYTES-1-n) +: 8] = in_name_key[8*(NAME_BYTES-1-n) +: 8];
      end
    end
  end

  // Sequencer status
  always_comb begin
    stat.not_last  = !(in_acc && in_last_item);
    stat.short_set = (count_r < CW'(2));
    stat.out_busy  = out_valid_r && out_stall;
    stat.more_j    = (j_r != last_idx);
    stat.more_i    = (i_inc != last_idx);
    stat.more_k    = (i_r != last_idx);
  end

  assign rd_addr  = (ctrl.rd_sel == RD_J) ? j_r : i_r;
  assign swap_hit = ctrl.try_swap && (cur_key_r > rd_key);

  // Store write port: load, swap into slot j, or put back slot i.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = {canon_key, in_record_tag};
    if (in_acc && !full) begin
      wr_en = 1'b1;
    end
    if (swap_hit) begin
      wr_en   = 1'b1;
      wr_addr = j_r;
      wr_data = {cur_key_r, cur_tag_r};
    end
    if (ctrl.wr_i) begin
      wr_en   = 1'b1;
      wr_addr = i_r;
      wr_data = {cur_key_r, cur_tag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Load: count the record or flag the drop.
      if (in_acc) begin
        if (full) begin
          drop_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end

      // Index counters
      if (ctrl.clr_i) begin
        i_r <= '0;
      end else if (ctrl.inc_i) begin
        i_r <= i_inc;
      end
      if (ctrl.set_j) begin
        j_r <= i_inc;
      end else if (ctrl.inc_j) begin
        j_r <= j_r + AW'(1);
      end

      // Held record i: take slot i, or swap in the smaller record j.
      if (ctrl.latch_cur || swap_hit) begin
        cur_key_r <= rd_key;
        cur_tag_r <= rd_tag;
      end

      // Result register: drop on acceptance, load on emit.
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
        out_key_r   <= rd_key;
        out_tag_r   <= rd_tag;
        out_final_r <= (i_r == last_idx);
        out_ovf_r   <= drop_r;
      end

      // End of set: start the next one empty.
      if (ctrl.clr_set) begin
        count_r <= '0;
        drop_r  <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sorted_key    = out_key_r;
  assign out_sorted_tag    = out_tag_r;
  assign out_final_result  = out_final_r;
  assign out_overflow_seen = out_ovf_r;

  // The store never holds more than DEPTH records.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("record count beyond store depth");

  // An emit never overwrites a result that is still waiting.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> !out_valid_r)
    else $error("emit while result register occupied");

  // Slot i is put back only for positions before the last one.
  a_puti_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_i |-> (i_r < last_idx))
    else $error("outer index out of range");

  // Input is taken only in the load step.
  a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
    (upc != STEP_IDLE) |-> in_stall)
    else $error("input accepted outside load step");

endmodule

/* sv/rsbn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rsbn_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/rsbn_seq.sv */
// Microcode sequencer: step counter, program table lookup and jump logic.
module rsbn_seq
  import rsbn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl,
  output upc_t  upc
);

  upc_t upc_r;
  upc_t upc_nxt;
  logic take_jump;

  assign ctrl = ucode_rom(upc_r);
  assign upc  = upc_r;

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    take_jump = 1'b0;
      COND_ALWAYS:   take_jump = 1'b1;
      COND_NOT_LAST: take_jump = stat.not_last;
      COND_SHORT:    take_jump = stat.short_set;
      COND_BUSY:     take_jump = stat.out_busy;
      COND_MORE_J:   take_jump = stat.more_j;
      COND_MORE_I:   take_jump = stat.more_i;
      COND_MORE_K:   take_jump = stat.more_k;
      default:       take_jump = 1'b1;
    endcase
    upc_nxt = take_jump ? ctrl.target : upc_r + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
